// ===== sv/lnp_pkg.sv =====
// ----------------------------------------------------------------------------
// lnp_pkg
// Shared types and constants for the nibble port pairing receiver.
// ----------------------------------------------------------------------------
package lnp_pkg;

	typedef enum logic [1:0] {
		ACT_PORT_WR = 2'd0,
		ACT_PORT_RD = 2'd1,
		ACT_BL_WR   = 2'd2,
		ACT_NONE    = 2'd3
	} action_t;

	// port bit positions
	localparam int PORT_RS_BIT = 1;
	localparam int PORT_E_BIT  = 2;

	localparam logic [3:0] WAKE_NIBBLE = 4'h3;
	localparam logic [1:0] WAKE_MAX    = 2'd3;
	localparam logic [2:0] FSET_TOP    = 3'b001;  // (byte & 0xE0) == 0x20
	localparam int         FSET_DL_BIT = 4;       // 0x10
	localparam int         BL_WIDTH    = 7;       // 0x7F mask

	typedef struct packed {
		logic                byte_valid;
		logic                byte_is_data;
		logic [7:0]          panel_byte;
		logic [7:0]          read_data;
		logic                backlight_valid;
		logic [BL_WIDTH-1:0] backlight_level;
	} result_t;

endpackage

// ===== sv/lnp_core.sv =====
// ----------------------------------------------------------------------------
// lnp_core
// Port state, wake counter and nibble pairing; one word per enabled cycle.
// ----------------------------------------------------------------------------
module lnp_core import lnp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  action_t    action,
	input  logic [7:0] write_data,
	output result_t    result
);

	logic [7:0] port_q;
	logic       mode8_q;
	logic       pend_q;
	logic [3:0] held_nib_q;
	logic       held_sel_q;
	logic [1:0] wake_q;

	logic [7:0] port_d;
	logic       mode8_d;
	logic       pend_d;
	logic [3:0] held_nib_d;
	logic       held_sel_d;
	logic [1:0] wake_d;

	always_comb begin
		logic [3:0] nib;
		logic       sel;
		logic       emit;
		logic       emit_sel;
		logic [7:0] emit_byte;

		port_d     = port_q;
		mode8_d    = mode8_q;
		pend_d     = pend_q;
		held_nib_d = held_nib_q;
		held_sel_d = held_sel_q;
		wake_d     = wake_q;
		result     = '0;

		nib       = {write_data[5], write_data[6], write_data[3], write_data[4]};
		sel       = write_data[PORT_RS_BIT];
		emit      = 1'b0;
		emit_sel  = 1'b0;
		emit_byte = '0;

		case (action)
			ACT_PORT_WR: begin
				port_d = write_data;
				if (!port_q[PORT_E_BIT] && write_data[PORT_E_BIT]) begin
					// wake sequence: three command nibbles of 3 in a row
					if (!sel && nib == WAKE_NIBBLE) begin
						if (wake_q != WAKE_MAX)
							wake_d = wake_q + 2'd1;
						if (wake_d == WAKE_MAX) begin
							mode8_d = 1'b1;
							pend_d  = 1'b0;
						end
					end else begin
						wake_d = '0;
					end

					if (mode8_d) begin
						if (!sel) begin
							emit      = 1'b1;
							emit_byte = {nib, 4'h0};
						end
					end else if (!pend_d) begin
						held_nib_d = nib;
						held_sel_d = sel;
						pend_d     = 1'b1;
					end else begin
						pend_d    = 1'b0;
						emit      = 1'b1;
						emit_sel  = held_sel_q;
						emit_byte = {held_nib_q, nib};
					end

					if (emit) begin
						// function set picks the interface width
						if (!emit_sel && emit_byte[7:5] == FSET_TOP) begin
							mode8_d = emit_byte[FSET_DL_BIT];
							pend_d  = 1'b0;
						end
						result.byte_valid   = 1'b1;
						result.byte_is_data = emit_sel;
						result.panel_byte   = emit_byte;
					end
				end
			end
			ACT_PORT_RD: begin
				result.read_data = port_q;
			end
			ACT_BL_WR: begin
				result.backlight_valid = 1'b1;
				result.backlight_level = write_data[BL_WIDTH-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_q     <= '0;
			mode8_q    <= 1'b1;
			pend_q     <= 1'b0;
			held_nib_q <= '0;
			held_sel_q <= 1'b0;
			wake_q     <= '0;
		end else if (step) begin
			port_q     <= port_d;
			mode8_q    <= mode8_d;
			pend_q     <= pend_d;
			held_nib_q <= held_nib_d;
			held_sel_q <= held_sel_d;
			wake_q     <= wake_d;
		end
	end

endmodule

// ===== sv/lcd_nibble_port_pairing.sv =====
// ----------------------------------------------------------------------------
// lcd_nibble_port_pairing
// Receiver for a byte-wide panel port driven in 4-bit fashion.
// ----------------------------------------------------------------------------
// Path: input register, then result register, which the word enters once the
// result slot is free. Throughput: one word per cycle while results are taken;
// the result register advances whenever the result is taken or it is empty,
// the input register also whenever it is empty.
// Reset: arst_n clears the pipeline valids and the port state; the receiver
// comes out of reset in 8-bit mode with no half byte pending.
// ----------------------------------------------------------------------------
module lcd_nibble_port_pairing import lnp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// input words
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] write_data
	input  logic [1:0]  s_tuser,   // [1:0] action
	// result words
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] panel_byte, [15:8] read_data,
	                               // [22:16] backlight_level, [23] zero
	output logic [2:0]  m_tuser    // [0] byte_valid, [1] byte_is_data,
	                               // [2] backlight_valid
);

	// input register
	logic       v_s1;
	action_t    act_s1;
	logic [7:0] data_s1;

	// result register
	logic       v_s2;
	result_t    res_s2;

	result_t    res;
	logic       out_free;
	logic       adv;

	// result slot free when empty or being drained this cycle
	assign out_free = !v_s2 || m_tready;
	// the word in the input register is processed as it moves to the result
	assign adv      = v_s1 && out_free;
	assign s_tready = !v_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			act_s1  <= action_t'(s_tuser);
			data_s1 <= s_tdata;
		end
	end

	// state update happens only on the advancing cycle, so a word that
	// follows directly sees the state left by the one before it
	lnp_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (adv),
		.action     (act_s1),
		.write_data (data_s1),
		.result     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (out_free) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = v_s2;
	assign m_tdata  = {1'b0, res_s2.backlight_level, res_s2.read_data, res_s2.panel_byte};
	assign m_tuser  = {res_s2.backlight_valid, res_s2.byte_is_data, res_s2.byte_valid};

endmodule
